// ===== src/button_press_classifier_assert.svh =====
`ifndef BUTTON_PRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define BPC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: label");

// next-cycle implication, disabled in reset
`define BPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: label");

`endif

// ===== src/bpc_pkg.sv =====
package bpc_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned CFG_W  = 16;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned IDX_W  = 2;

	localparam logic [CFG_W-1:0] POLL_TIMEOUT_RST = 16'd50;
	localparam logic [CFG_W-1:0] DEBOUNCE_RST     = 16'd10;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd1000;

	localparam logic [IDX_W-1:0] IDX_POLL_TIMEOUT = 2'd0;
	localparam logic [IDX_W-1:0] IDX_DEBOUNCE     = 2'd1;
	localparam logic [IDX_W-1:0] IDX_LONG_PRESS   = 2'd2;

	localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SHORT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LONG  = 2'd2;

	typedef enum logic [4:0] {
		PH_IDLE       = 5'b00001,
		PH_TENT_PRESS = 5'b00010,
		PH_SHORT      = 5'b00100,
		PH_LONG       = 5'b01000,
		PH_TENT_REL   = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [CFG_W-1:0] poll_timeout_ms;
		logic [CFG_W-1:0] debounce_ms;
		logic [CFG_W-1:0] long_press_ms;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0] now_ms;
		logic              pin_level;
	} sample_t;

endpackage

// ===== src/bpc_if.sv =====
interface bpc_in_if;
	logic                           valid;
	logic                           ready;
	logic [bpc_pkg::TIME_W-1:0]     now_ms;
	logic                           pin_level;

	modport source (output valid, output now_ms, output pin_level, input ready);
	modport sink   (input valid, input now_ms, input pin_level, output ready);
endinterface

interface bpc_out_if;
	logic                           valid;
	logic                           ready;
	logic [bpc_pkg::KIND_W-1:0]     press_kind;

	modport source (output valid, output press_kind, input ready);
	modport sink   (input valid, input press_kind, output ready);
endinterface

// ===== src/bpc_cfg_regs.sv =====
module bpc_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bpc_pkg::IDX_W-1:0]    cfg_index,
	input  logic [bpc_pkg::CFG_W-1:0]    cfg_wdata,
	output bpc_pkg::cfg_t                cfg
);

	bpc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poll_timeout_ms <= bpc_pkg::POLL_TIMEOUT_RST;
			cfg_q.debounce_ms     <= bpc_pkg::DEBOUNCE_RST;
			cfg_q.long_press_ms   <= bpc_pkg::LONG_PRESS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bpc_pkg::IDX_POLL_TIMEOUT: cfg_q.poll_timeout_ms <= cfg_wdata;
				bpc_pkg::IDX_DEBOUNCE:     cfg_q.debounce_ms     <= cfg_wdata;
				bpc_pkg::IDX_LONG_PRESS:   cfg_q.long_press_ms   <= cfg_wdata;
				default: ; // index past the list: dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/bpc_fsm.sv =====
module bpc_fsm (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  bpc_pkg::sample_t              sample,
	input  bpc_pkg::cfg_t                 cfg,
	output logic [bpc_pkg::KIND_W-1:0]    kind
);

	bpc_pkg::phase_t               phase_q, phase_d;
	logic [bpc_pkg::TIME_W-1:0]    press_start_q, press_start_d;
	logic [bpc_pkg::TIME_W-1:0]    change_q, change_d;
	logic [bpc_pkg::TIME_W-1:0]    last_poll_q;

	logic [bpc_pkg::TIME_W-1:0]    held, since_change, gap;
	logic                          pressed, timed_out, debounced, is_long;

	// all differences wrap mod 2^32
	assign held         = sample.now_ms - press_start_q;
	assign since_change = sample.now_ms - change_q;
	assign gap          = sample.now_ms - last_poll_q;
	assign pressed      = ~sample.pin_level;
	assign timed_out    = gap > {{(bpc_pkg::TIME_W-bpc_pkg::CFG_W){1'b0}}, cfg.poll_timeout_ms};
	assign debounced    = since_change >=
		{{(bpc_pkg::TIME_W-bpc_pkg::CFG_W){1'b0}}, cfg.debounce_ms};
	assign is_long      = held >= {{(bpc_pkg::TIME_W-bpc_pkg::CFG_W){1'b0}}, cfg.long_press_ms};

	always_comb begin
		phase_d       = phase_q;
		press_start_d = press_start_q;
		change_d      = change_q;
		kind          = bpc_pkg::KIND_NONE;
		if (timed_out) begin
			phase_d = bpc_pkg::PH_IDLE;
		end else begin
			unique case (phase_q)
				bpc_pkg::PH_TENT_PRESS: begin
					if (!pressed) begin
						phase_d  = bpc_pkg::PH_IDLE;
						change_d = sample.now_ms;
					end else if (debounced) begin
						phase_d       = bpc_pkg::PH_SHORT;
						press_start_d = sample.now_ms;
					end
				end
				bpc_pkg::PH_SHORT: begin
					if (!pressed) begin
						phase_d  = bpc_pkg::PH_TENT_REL;
						change_d = sample.now_ms;
					end else if (is_long) begin
						phase_d = bpc_pkg::PH_LONG;
					end
				end
				bpc_pkg::PH_LONG: begin
					if (!pressed) begin
						phase_d  = bpc_pkg::PH_TENT_REL;
						change_d = sample.now_ms;
					end
				end
				bpc_pkg::PH_TENT_REL: begin
					if (pressed) begin
						phase_d  = is_long ? bpc_pkg::PH_LONG : bpc_pkg::PH_SHORT;
						change_d = sample.now_ms;
					end else if (debounced) begin
						phase_d = bpc_pkg::PH_IDLE;
						kind    = is_long ? bpc_pkg::KIND_LONG : bpc_pkg::KIND_SHORT;
					end
				end
				default: begin // idle, and any stray code
					if (pressed) begin
						phase_d  = bpc_pkg::PH_TENT_PRESS;
						change_d = sample.now_ms;
					end else begin
						phase_d = bpc_pkg::PH_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= bpc_pkg::PH_IDLE;
			press_start_q <= '0;
			change_q      <= '0;
			last_poll_q   <= '0;
		end else if (step) begin
			phase_q       <= phase_d;
			press_start_q <= press_start_d;
			change_q      <= change_d;
			last_poll_q   <= sample.now_ms;
		end
	end

endmodule

// ===== src/button_press_classifier.sv =====
// An accepted sample word is held in the input register, then its result word in the result register.
// Throughput: one sample word per cycle, sustained while the result side takes words.
// The rate is set by the state update in bpc_fsm (one compare pass per word).
// Reset (arst_n low, asynchronous): idle phase, all timestamps zero, registers to
// 50/10/1000 ms, both pipeline stages empty.
module button_press_classifier (
	input  logic                          clk,
	input  logic                          arst_n,
	bpc_in_if.sink                        sample_in,
	bpc_out_if.source                     result_out,
	input  logic                          cfg_we,
	input  logic [bpc_pkg::IDX_W-1:0]     cfg_index,
	input  logic [bpc_pkg::CFG_W-1:0]     cfg_wdata
);

	// input register
	logic                          valid_s1;
	bpc_pkg::sample_t              sample_s1;

	// result register
	logic                          valid_q;
	logic [bpc_pkg::KIND_W-1:0]    kind_q;

	logic                          adv;     // stage 1 moves into the result register
	logic                          step;    // state machine consumes the stage 1 word
	logic                          take;    // sample word accepted this edge
	logic [bpc_pkg::KIND_W-1:0]    kind;
	bpc_pkg::cfg_t                 cfg;

	// result slot is free or being emptied this cycle
	assign adv  = !valid_q || result_out.ready;
	assign step = valid_s1 && adv;
	// stage 1 refills as it drains, so a word can enter every cycle unless the result side stalls
	assign sample_in.ready = !valid_s1 || adv;
	assign take = sample_in.valid && sample_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_in.ready) begin
			valid_s1 <= sample_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sample_s1.now_ms    <= sample_in.now_ms;
			sample_s1.pin_level <= sample_in.pin_level;
		end
	end

	bpc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// debounce machine; state advances once per word leaving stage 1
	bpc_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.sample (sample_s1),
		.cfg    (cfg),
		.kind   (kind)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			kind_q <= kind;
		end
	end

	assign result_out.valid      = valid_q;
	assign result_out.press_kind = kind_q;

endmodule

// ===== src/bpc_checker.sv =====
`include "button_press_classifier_assert.svh"

module bpc_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [bpc_pkg::KIND_W-1:0]    press_kind
);

	// stalled result word holds
	`BPC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(press_kind))

	// only defined result codes
	`BPC_ASSERT_IMPL(a_kind_legal, clk, arst_n, out_valid, press_kind <= bpc_pkg::KIND_LONG)

	// input side never waits unless the result side is stalled
	`BPC_ASSERT_IMPL(a_no_idle_stall, clk, arst_n, !out_valid || out_ready, in_ready)

	// a fresh result word comes from a sample word that was taken and passed straight through the input register
	`BPC_ASSERT_IMPL(a_out_origin, clk, arst_n, $rose(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (sample_in.valid),
	.in_ready   (sample_in.ready),
	.out_valid  (result_out.valid),
	.out_ready  (result_out.ready),
	.press_kind (result_out.press_kind)
);

// ===== tb/sv/button_press_classifier_tb.sv =====
module button_press_classifier_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bpc_pkg::*;

	// Index 3 has no register behind it; a write there must change nothing.
	localparam logic [IDX_W-1:0] IDX_SPARE = 2'd3;

	// Runaway guard.
	localparam int CYCLE_LIMIT = 600000;
	// Long receiver hold-off, so the block fills up and stalls its input.
	localparam int HOLD_CYCLES = 300;

	// Receiver ready patterns; each one runs for a random stretch.
	typedef enum int {RX_STREAM, RX_COIN, RX_SLOW, RX_EVERY_THIRD} rx_mode_t;

	// Tracks the debounce machine one poll at a time and keeps the press
	// kinds still owed by the block, oldest first.
	class press_tracker;
		cfg_t              regs;
		phase_t            cur_phase;
		logic [TIME_W-1:0] press_start;
		logic [TIME_W-1:0] level_change;
		logic [TIME_W-1:0] last_poll;
		logic [KIND_W-1:0] pending_kinds[$];
		int                mismatches;

		function new();
			regs.poll_timeout_ms = POLL_TIMEOUT_RST;
			regs.debounce_ms     = DEBOUNCE_RST;
			regs.long_press_ms   = LONG_PRESS_RST;
			cur_phase    = PH_IDLE;
			press_start  = '0;
			level_change = '0;
			last_poll    = '0;
			mismatches   = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			case (idx)
				IDX_POLL_TIMEOUT: regs.poll_timeout_ms = val;
				IDX_DEBOUNCE:     regs.debounce_ms = val;
				IDX_LONG_PRESS:   regs.long_press_ms = val;
				default: ;
			endcase
		endfunction

		// One poll: advance the machine, return the press kind it completes.
		function logic [KIND_W-1:0] classify_poll(logic [TIME_W-1:0] now, logic pin);
			logic [TIME_W-1:0] held;
			logic [TIME_W-1:0] since_change;
			logic [TIME_W-1:0] poll_gap;
			logic              pressed;
			logic [KIND_W-1:0] kind;
			held         = now - press_start;
			since_change = now - level_change;
			poll_gap     = now - last_poll;
			pressed      = !pin;
			kind         = KIND_NONE;
			// stale poll: drop back to idle, no press reported
			if (poll_gap > {16'b0, regs.poll_timeout_ms}) begin
				cur_phase = PH_IDLE;
				last_poll = now;
				return KIND_NONE;
			end
			last_poll = now;
			case (cur_phase)
				PH_TENT_PRESS: begin
					if (!pressed) begin
						cur_phase    = PH_IDLE;
						level_change = now;
					end else if (since_change >= {16'b0, regs.debounce_ms}) begin
						cur_phase   = PH_SHORT;
						press_start = now;
					end
				end
				PH_SHORT: begin
					if (!pressed) begin
						cur_phase    = PH_TENT_REL;
						level_change = now;
					end else if (held >= {16'b0, regs.long_press_ms}) begin
						cur_phase = PH_LONG;
					end
				end
				PH_LONG: begin
					if (!pressed) begin
						cur_phase    = PH_TENT_REL;
						level_change = now;
					end
				end
				PH_TENT_REL: begin
					if (pressed) begin
						cur_phase    = (held < {16'b0, regs.long_press_ms}) ? PH_SHORT : PH_LONG;
						level_change = now;
					end else if (since_change >= {16'b0, regs.debounce_ms}) begin
						cur_phase = PH_IDLE;
						kind      = (held < {16'b0, regs.long_press_ms}) ? KIND_SHORT : KIND_LONG;
					end
				end
				default: begin
					if (pressed) begin
						cur_phase    = PH_TENT_PRESS;
						level_change = now;
					end else begin
						cur_phase = PH_IDLE;
					end
				end
			endcase
			return kind;
		endfunction

		function void note_sample(logic [TIME_W-1:0] now, logic pin);
			pending_kinds.push_back(classify_poll(now, pin));
		endfunction

		function int pending();
			return pending_kinds.size();
		endfunction

		task report(string what);
			if (mismatches < 40)
				$display("[%0t] mismatch: %s", $time, what);
			mismatches++;
		endtask

		task check_kind(logic [KIND_W-1:0] got);
			logic [KIND_W-1:0] want;
			if (pending_kinds.size() == 0) begin
				report($sformatf("press_kind %0d with no sample word outstanding", got));
			end else begin
				want = pending_kinds.pop_front();
				if (got !== want)
					report($sformatf("press_kind %0d, predicted %0d", got, want));
			end
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]   cfg_wdata;

	bpc_in_if  sample_if();
	bpc_out_if result_if();

	press_tracker tracker = new();

	// Stimulus bookkeeping: the tb's own view of time and of the registers.
	logic [TIME_W-1:0] clock_ms = '0;
	int                cfg_timeout = POLL_TIMEOUT_RST;
	int                cfg_debounce = DEBOUNCE_RST;
	int                cfg_long = LONG_PRESS_RST;
	int                items_sent = 0;
	int                burst_left = 0;
	bit                no_gaps = 1'b0;

	// Receiver state. hold_seq is bumped by the stimulus to request a hold-off.
	int       hold_seq = 0;
	int       hold_seen = 0;
	int       stall_left = 0;
	int       mode_left = 0;
	rx_mode_t rx_mode = RX_STREAM;
	int       cycle_count = 0;

	button_press_classifier uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample_in  (sample_if),
		.result_out (result_if),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("button_press_classifier_tb NOT OK");
			$finish;
		end
	end

	// Both handshakes are sampled at the edge, before any NBA lands, so the
	// tracker sees exactly the words the block takes and gives.
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_if.valid && sample_if.ready)
				tracker.note_sample(sample_if.now_ms, sample_if.pin_level);
			if (result_if.valid && result_if.ready)
				tracker.check_kind(result_if.press_kind);
		end
	end

	// Receiver: a long hold-off when asked, otherwise a ready pattern picked at
	// random and changed after a random run (streaming, coin flip, slow, periodic).
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left      <= stall_left - 1;
			result_if.ready <= 1'b0;
		end else if (hold_seq != hold_seen) begin
			hold_seen       <= hold_seq;
			stall_left      <= HOLD_CYCLES;
			result_if.ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode   <= rx_mode_t'($urandom_range(0, 3));
				mode_left <= $urandom_range(20, 200);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (rx_mode)
				RX_STREAM: result_if.ready <= 1'b1;
				RX_COIN:   result_if.ready <= ($urandom_range(0, 1) == 1);
				RX_SLOW:   result_if.ready <= ($urandom_range(0, 3) == 0);
				default:   result_if.ready <= (cycle_count % 3 == 0);
			endcase
		end
	end

	// Offer one sample word and hold it until taken. Between bursts the
	// sender idles for a random gap, unless no_gaps is set.
	task automatic put_sample(input logic [TIME_W-1:0] t, input logic pin);
		int idle;
		if (!no_gaps && burst_left <= 0) begin
			idle = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 6);
			sample_if.valid <= 1'b0;
			repeat (idle) @(posedge clk);
			// now and then a long run with no idling at all
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
			                                         : $urandom_range(1, 12);
		end
		sample_if.valid     <= 1'b1;
		sample_if.now_ms    <= t;
		sample_if.pin_level <= pin;
		@(posedge clk);
		while (!sample_if.ready) @(posedge clk);
		burst_left--;
		items_sent++;
	endtask

	// Advance the poll clock and send one sample. Mostly gaps within the
	// timeout; rarely a stale gap or a jump to an arbitrary time.
	task automatic poll(input logic pin);
		if ($urandom_range(0, 199) == 0)
			clock_ms = $urandom;
		else if ($urandom_range(0, 49) == 0)
			clock_ms += cfg_timeout + $urandom_range(1, 20);
		else
			clock_ms += $urandom_range(0, cfg_timeout);
		put_sample(clock_ms, pin);
	endtask

	// Stop sending and wait until every predicted word has come back.
	task automatic drain_results();
		sample_if.valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input int val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_W'(val);
		tracker.write_reg(idx, CFG_W'(val));
		@(posedge clk);
	endtask

	// All three registers plus a junk write to the unused index.
	task automatic apply_config(input int timeout_ms, input int deb_ms, input int lng_ms);
		write_reg(IDX_POLL_TIMEOUT, timeout_ms);
		write_reg(IDX_DEBOUNCE, deb_ms);
		write_reg(IDX_LONG_PRESS, lng_ms);
		write_reg(IDX_SPARE, $urandom_range(0, 65535));
		cfg_we       <= 1'b0;
		cfg_timeout  = timeout_ms;
		cfg_debounce = deb_ms;
		cfg_long     = lng_ms;
	endtask

	// A well-formed press: idle, bouncy press held for a random length around
	// the long threshold (or a blip no longer than the debounce), bouncy release.
	task automatic press_sequence();
		int                hold_ms;
		int                rel_ms;
		int                n;
		logic [TIME_W-1:0] start;
		repeat ($urandom_range(1, 3)) poll(1'b1);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: hold_ms = cfg_debounce + $urandom_range(0, cfg_long);
			4, 5, 6:    hold_ms = cfg_debounce + cfg_long
			                      + $urandom_range(0, cfg_long / 2 + cfg_timeout);
			7:          hold_ms = cfg_debounce + cfg_long + $urandom_range(0, 2);
			default:    hold_ms = $urandom_range(0, cfg_debounce);
		endcase
		start = clock_ms;
		n     = 0;
		do begin
			poll($urandom_range(0, 15) == 0);
			n++;
		end while ((clock_ms - start) < 32'(hold_ms) && n < 60);
		rel_ms = cfg_debounce + $urandom_range(0, cfg_timeout);
		start  = clock_ms;
		n      = 0;
		do begin
			poll($urandom_range(0, 15) != 0);
			n++;
		end while ((clock_ms - start) < 32'(rel_ms) && n < 60);
	endtask

	task automatic noise_burst();
		repeat ($urandom_range(1, 8)) poll($urandom_range(0, 1));
	endtask

	// One register setting: drain, reconfigure, maybe start near the 2^32
	// wrap, optionally squeeze the block under a receiver hold-off, then run.
	task automatic run_phase(input int timeout_ms, input int deb_ms, input int lng_ms,
	                         input int count, input bit squeeze);
		int stop;
		drain_results();
		apply_config(timeout_ms, deb_ms, lng_ms);
		if ($urandom_range(0, 1))
			clock_ms = 32'd0 - 32'($urandom_range(0, 3000));
		if (squeeze) begin
			stop     = items_sent + 80;
			hold_seq <= hold_seq + 1;
			no_gaps  = 1'b1;
			while (items_sent < stop) press_sequence();
			no_gaps = 1'b0;
		end
		stop = items_sent + count;
		while (items_sent < stop) begin
			if ($urandom_range(0, 9) == 0)
				noise_burst();
			else
				press_sequence();
		end
	endtask

	initial begin
		int rt;
		int rd;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = IDX_POLL_TIMEOUT;
		cfg_wdata           = '0;
		sample_if.valid     = 1'b0;
		sample_if.now_ms    = '0;
		sample_if.pin_level = 1'b1;
		result_if.ready     = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset registers (50/10/1000): a short press with a bounce
		// on release, then a stale poll.
		put_sample(32'd0, 1'b1);
		put_sample(32'd5, 1'b0);
		put_sample(32'd16, 1'b0);
		put_sample(32'd30, 1'b1);
		put_sample(32'd35, 1'b0);
		put_sample(32'd40, 1'b1);
		put_sample(32'd50, 1'b1);
		put_sample(32'd200, 1'b0);
		// short press straddling the 2^32 wrap, time at all ones on the way
		put_sample(32'hFFFF_FFF0, 1'b1);
		put_sample(32'hFFFF_FFF8, 1'b0);
		put_sample(32'hFFFF_FFFF, 1'b0);
		put_sample(32'd4, 1'b0);
		put_sample(32'd9, 1'b1);
		put_sample(32'd19, 1'b1);
		drain_results();

		// Zero thresholds: every stage is met on the very next poll and any
		// advance in time is stale.
		apply_config(0, 0, 0);
		put_sample(32'd100, 1'b0);
		repeat (3) put_sample(32'd100, 1'b0);
		repeat (2) put_sample(32'd100, 1'b1);
		drain_results();

		// All thresholds at their maximum, each met exactly.
		apply_config(65535, 65535, 65535);
		put_sample(32'd65635, 1'b0);
		put_sample(32'd131170, 1'b0);
		put_sample(32'd196705, 1'b0);
		put_sample(32'd196705, 1'b1);
		put_sample(32'd262240, 1'b1);
		clock_ms = 32'd262240;

		// Random part.
		run_phase(20, 5, 60, 240, 1'b0);
		run_phase(POLL_TIMEOUT_RST, DEBOUNCE_RST, LONG_PRESS_RST, 240, 1'b0);
		run_phase(0, 0, 0, 200, 1'b0);
		run_phase(65535, 65535, 65535, 200, 1'b0);
		rt = $urandom_range(4, 60);
		rd = $urandom_range(0, rt);
		run_phase(rt, rd, $urandom_range(rd, 4 * rt + rd), 240, 1'b1);
		run_phase(12, 0, 30, 240, 1'b0);
		run_phase(30, 25, 40, 240, 1'b0);
		rt = $urandom_range(1, 300);
		rd = $urandom_range(0, rt);
		run_phase(rt, rd, $urandom_range(0, 2000), 240, 1'b0);

		// Everything predicted must be back; then a short tail to catch strays.
		drain_results();
		repeat (10) @(posedge clk);
		if (tracker.mismatches == 0) begin
			$display("button_press_classifier_tb OK");
		end else begin
			$display("button_press_classifier_tb NOT OK");
		end
		$finish;
	end

endmodule

// ===== button_press_classifier.f =====
+incdir+src
src/bpc_pkg.sv
src/bpc_if.sv
src/bpc_cfg_regs.sv
src/bpc_fsm.sv
src/button_press_classifier.sv
src/bpc_checker.sv
tb/sv/button_press_classifier_tb.sv
